// ----- rtl/rita_pkg.sv -----
`default_nettype none

package rita_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RADIX     = 2'd0;
    localparam logic [1:0] CFG_TABLE_LOW  = 2'd1;
    localparam logic [1:0] CFG_TABLE_HIGH = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned RADIX_W     = 5;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [63:0]        TABLE_LOW_RESET  = 64'h3736353433323130;
    localparam logic [63:0]        TABLE_HIGH_RESET = 64'h6665646362613938;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;

    typedef struct packed {
        logic load;   // take a new value, clear the digit cells
        logic step;   // shift one magnitude bit through the cell row
        logic emit;   // move one character into the output register
    } rita_cmd_t;

    typedef struct packed {
        logic conv_done;  // this step is the final one of the conversion
        logic last_char;  // the next character to leave is the final one
        logic out_free;   // output register can take a character this cycle
    } rita_status_t;

endpackage

`default_nettype wire

// ----- rtl/radix_integer_to_ascii.sv -----
// Integer to ASCII text in a configurable base.
// Input item (s_axis): tdata holds the value, tuser the request type
// (0 signed two's complement, 1 unsigned). Only the low VALUE_BITS bits count.
// Output (m_axis): one character per item, most significant digit first, no
// leading zeros, a leading minus for a negative signed value; tlast marks the
// final character of each number.
// Configuration: write cfg_data to register cfg_index while cfg_we is high:
// 0 radix (2..16, clamped), 1 symbols for digits 0..7, 2 symbols for 8..15.
// Sequence: a load, then the magnitude bits pass through the row of
// digit cells (the bit stream climbs the row one cell a cycle), then one
// character a cycle while the receiver takes them; an N-character result
// has N at most VALUE_BITS+1.
// A stalled receiver holds the output register and pauses emission; the next
// item is taken as soon as the final character sits in the output register.
// Reset restores radix 10 and the table "0123456789abcdef" and empties the
// output register.
`default_nettype none

module radix_integer_to_ascii #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [31:0]                          s_axis_tdata,  // value[31:0]
    input  wire                                 s_axis_tuser,  // req_type
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // character[7:0]
    output logic                                m_axis_tlast,
    input  wire                                 cfg_we,
    input  wire [rita_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [rita_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [rita_pkg::RADIX_W-1:0] radix_reg;
    logic [63:0]                  table_low_reg;
    logic [63:0]                  table_high_reg;
    logic [rita_pkg::RADIX_W-1:0] radix_eff;

    rita_pkg::rita_cmd_t    cmd;
    rita_pkg::rita_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= rita_pkg::RADIX_RESET;
            table_low_reg  <= rita_pkg::TABLE_LOW_RESET;
            table_high_reg <= rita_pkg::TABLE_HIGH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rita_pkg::CFG_RADIX:      radix_reg      <= cfg_data[rita_pkg::RADIX_W-1:0];
                rita_pkg::CFG_TABLE_LOW:  table_low_reg  <= cfg_data;
                rita_pkg::CFG_TABLE_HIGH: table_high_reg <= cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        priority if (radix_reg < rita_pkg::MIN_RADIX) begin
            radix_eff = rita_pkg::MIN_RADIX;
        end else if (radix_reg > rita_pkg::MAX_RADIX) begin
            radix_eff = rita_pkg::MAX_RADIX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    rita_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rita_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .req_type   (s_axis_tuser),
        .value      (s_axis_tdata),
        .radix      (radix_eff),
        .table_low  (table_low_reg),
        .table_high (table_high_reg),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_char   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/rita_ctrl.sv -----
`default_nettype none

module rita_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  rita_pkg::rita_status_t status,
    output rita_pkg::rita_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (status.conv_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_char) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rita_dp.sv -----
`default_nettype none

module rita_dp #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  rita_pkg::rita_cmd_t                 cmd,
    output rita_pkg::rita_status_t              status,
    input  wire                                 req_type,
    input  wire [31:0]                          value,
    input  wire [rita_pkg::RADIX_W-1:0]         radix,
    input  wire [63:0]                          table_low,
    input  wire [63:0]                          table_high,
    input  wire                                 out_ready,
    output logic                                out_valid,
    output logic [7:0]                          out_char,
    output logic                                out_last
);

    localparam int unsigned NCELLS = VALUE_BITS;
    localparam int unsigned TOP_W  = $clog2(NCELLS);
    localparam int unsigned STEP_W = $clog2(2 * VALUE_BITS);
    localparam logic [TOP_W-1:0]  TOP_MAX   = TOP_W'(NCELLS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS + NCELLS - 2);

    logic [VALUE_BITS-1:0] mag_reg;
    logic [3:0]            cell_reg [NCELLS];
    logic [NCELLS-1:0]     carry_reg;
    logic [TOP_W-1:0]      top_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  minus_pend_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_char_reg;
    logic                  out_last_reg;

    logic [VALUE_BITS+31:0] value_wide;
    logic [VALUE_BITS-1:0]  value_in;
    logic                   neg_in;
    logic [127:0]           symbols;
    logic [3:0]             digit_sel;
    logic [7:0]             symbol;

    assign value_wide = {{VALUE_BITS{1'b0}}, value};
    assign value_in   = value_wide[VALUE_BITS-1:0];
    assign neg_in     = !req_type && value_in[VALUE_BITS-1];

    assign symbols   = {table_high, table_low};
    assign digit_sel = cell_reg[top_reg];
    assign symbol    = symbols[{digit_sel, 3'b000} +: 8];

    assign status.conv_done = (step_reg == LAST_STEP);
    assign status.last_char = !minus_pend_reg && (top_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // Magnitude, step count and sign
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg        <= neg_in ? (~value_in + 1'b1) : value_in;
            step_reg       <= '0;
            minus_pend_reg <= neg_in;
        end else begin
            if (cmd.step) begin
                mag_reg  <= {mag_reg[VALUE_BITS-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.emit) begin
                minus_pend_reg <= 1'b0;
            end
        end
    end

    // Row of digit cells: each doubles its digit and adds the carry from below,
    // carries are registered so the bit stream ripples up one cell a cycle
    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        localparam logic [STEP_W:0] END_STEP = (STEP_W + 1)'(i + VALUE_BITS);

        logic       cin;
        logic [4:0] sum;
        logic       ge;
        logic       active;

        if (i == 0) begin : g_first
            assign cin = mag_reg[VALUE_BITS-1];
        end else begin : g_rest
            assign cin = carry_reg[i-1];
        end

        assign sum    = {cell_reg[i], cin};
        assign ge     = (sum >= radix);
        assign active = ({1'b0, step_reg} < END_STEP);

        always_ff @(posedge aclk) begin
            if (cmd.load) begin
                cell_reg[i]  <= '0;
                carry_reg[i] <= 1'b0;
            end else if (cmd.step) begin
                if (active) begin
                    cell_reg[i]  <= ge ? 4'(sum - radix) : sum[3:0];
                    carry_reg[i] <= ge;
                end else begin
                    carry_reg[i] <= 1'b0;
                end
            end
        end
    end

    // Highest used cell grows by at most one per step; it then walks down as digits leave
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            top_reg <= '0;
        end else if (cmd.step) begin
            if (carry_reg[top_reg] && (top_reg != TOP_MAX)) begin
                top_reg <= top_reg + 1'b1;
            end
        end else if (cmd.emit && !minus_pend_reg && (top_reg != '0)) begin
            top_reg <= top_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_char_reg <= minus_pend_reg ? rita_pkg::MINUS_CHAR : symbol;
            out_last_reg <= status.last_char;
        end
    end

endmodule

`default_nettype wire
